FILE: hw/rtl/bqpc_pkg.sv
package bqpc_pkg;

	localparam int CFG_W     = 11;
	localparam int PIXEL_W   = 8;
	localparam int COUNT_W   = 20;
	localparam int REG_IDX_W = 1;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DIM_MIN        = 2;

	localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(64);

	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = REG_IDX_W'(1);

	// last member sits in the lowest bits
	typedef struct packed {
		logic [COUNT_W-1:0] triple;
		logic [COUNT_W-1:0] pair_diagonal;
		logic [COUNT_W-1:0] pair_adjacent;
		logic [COUNT_W-1:0] single;
	} counts_t;

	localparam int OUT_W = $bits(counts_t);

endpackage

FILE: hw/rtl/bqpc_ram.sv
module bqpc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a write returns the old contents
	always_ff @(posedge clk) begin
		if (en) begin
			rdata <= mem[addr];
			if (we) begin
				mem[addr] <= wdata;
			end
		end
	end

endmodule

FILE: hw/rtl/bit_quad_pattern_counter.sv
// Bit-quad pattern counter.
// Pixels enter on the s_ stream in raster order, one request per pixel; a
// nonzero sample counts as set. Image size comes from the config port
// (register 0 image_width, register 1 image_height, clamped to 2..MAX),
// to be written by the user only while the block is idle (not enforced).
// Each 2x2 window fully inside the image is sorted into single, adjacent
// pair, diagonal pair or triple, and a count is kept per class.
// After the last pixel of an image one request leaves on the m_ stream with
// the four counts; the counts then start again from zero.
// Throughput: one pixel per cycle, set by the single read-first access to
// the one-bit line store that each pixel makes (read above, write current).
// This rate holds outside the stall below; m_tvalid is driven by a register.
// The result waits in an output register while m_tready is low; pixels keep
// flowing, and only the last pixel of the next image waits in the second
// stage if the previous result is still untaken.
// Reset clears positions, counts and the size registers (64 x 64). The line
// store needs no clearing pass: the first row never uses it.
module bit_quad_pattern_counter #(
	parameter int MAX_WIDTH  = bqpc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bqpc_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bqpc_pkg::PIXEL_W-1:0]   s_tdata,   // pixel
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// count_single, count_pair_adjacent, count_pair_diagonal, count_triple
	output logic [bqpc_pkg::OUT_W-1:0]     m_tdata,
	input  logic                           cfg_we,
	input  logic [bqpc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [bqpc_pkg::CFG_W-1:0]     cfg_data
);

	import bqpc_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int W_CW  = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
	localparam int H_CW  = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

	logic [CFG_W-1:0] cfg_w_q, cfg_h_q;
	logic [W_CW-1:0]  w_use;
	logic [H_CW-1:0]  h_use;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             s_fire, cur_bit, last_col, last_row;

	logic s1_valid_q, s1_cur_s1, s1_cls_s1, s1_upen_s1, s1_eol_s1, s1_eoi_s1;
	logic s1_adv, s1_fire;
	logic ram_rdata;
	logic left_q, ul_q, up_bit;
	logic [2:0] n_set;
	logic is_single, is_adj, is_diag, is_triple;

	counts_t totals_q, totals_nxt, out_q;
	logic    out_valid_q;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v,
		input logic en);
		logic [COUNT_W-1:0] r;
		r = v;
		if (en && (v != {COUNT_W{1'b1}})) begin
			r = v + COUNT_W'(1);
		end
		return r;
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= DIM_RESET;
			cfg_h_q <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_w_q <= cfg_data;
				REG_IMAGE_HEIGHT: cfg_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cfg_w_q < CFG_W'(DIM_MIN)) begin
			w_use = W_CW'(DIM_MIN);
		end else if (W_CW'(cfg_w_q) > W_CW'(MAX_WIDTH)) begin
			w_use = W_CW'(MAX_WIDTH);
		end else begin
			w_use = W_CW'(cfg_w_q);
		end
		if (cfg_h_q < CFG_W'(DIM_MIN)) begin
			h_use = H_CW'(DIM_MIN);
		end else if (H_CW'(cfg_h_q) > H_CW'(MAX_HEIGHT)) begin
			h_use = H_CW'(MAX_HEIGHT);
		end else begin
			h_use = H_CW'(cfg_h_q);
		end
	end

	// stage 0: position tracking and line store access
	assign s_tready = !s1_valid_q || s1_adv;
	assign s_fire   = s_tvalid && s_tready;
	assign cur_bit  = (s_tdata != '0);
	assign last_col = (W_CW'(col_q) + W_CW'(1)) >= w_use;
	assign last_row = (H_CW'(row_q) + H_CW'(1)) >= h_use;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_fire) begin
			if (!last_col) begin
				col_q <= col_q + COL_W'(1);
			end else begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end
		end
	end

	bqpc_ram #(
		.WIDTH (1),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.en    (s_fire),
		.we    (1'b1),
		.addr  (col_q),
		.wdata (cur_bit),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			s1_cur_s1  <= cur_bit;
			s1_cls_s1  <= (row_q != '0) && (col_q != '0);
			s1_upen_s1 <= (row_q != '0);
			s1_eol_s1  <= last_col;
			s1_eoi_s1  <= last_col && last_row;
		end
	end

	// stage 1: classify window, update counts
	assign s1_adv  = !(s1_eoi_s1 && out_valid_q && !m_tready);
	assign s1_fire = s1_valid_q && s1_adv;
	assign up_bit  = s1_upen_s1 && ram_rdata;
	assign n_set   = 3'(ul_q) + 3'(up_bit) + 3'(left_q) + 3'(s1_cur_s1);

	always_comb begin
		is_single = s1_cls_s1 && (n_set == 3'd1);
		is_triple = s1_cls_s1 && (n_set == 3'd3);
		is_diag   = s1_cls_s1 && (n_set == 3'd2) &&
			((ul_q && s1_cur_s1) || (up_bit && left_q));
		is_adj    = s1_cls_s1 && (n_set == 3'd2) && !is_diag;
		totals_nxt.single        = sat_inc(totals_q.single, is_single);
		totals_nxt.pair_adjacent = sat_inc(totals_q.pair_adjacent, is_adj);
		totals_nxt.pair_diagonal = sat_inc(totals_q.pair_diagonal, is_diag);
		totals_nxt.triple        = sat_inc(totals_q.triple, is_triple);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= 1'b0;
			ul_q     <= 1'b0;
			totals_q <= '0;
		end else if (s1_fire) begin
			left_q   <= s1_eol_s1 ? 1'b0 : s1_cur_s1;
			ul_q     <= s1_eol_s1 ? 1'b0 : up_bit;
			totals_q <= s1_eoi_s1 ? '0 : totals_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && s1_eoi_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && s1_eoi_s1) begin
			out_q <= totals_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// checks
	a_row_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_upen_s1) || (s1_valid_q && !s1_cls_s1 && s1_upen_s1)
		|-> (!left_q || s1_cls_s1 || s1_upen_s1 == 1'b0 || s1_cls_s1 == s1_upen_s1
		|| !ul_q))
		else $error("window state not cleared at row start");

	a_result_from_eoi: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_valid_q && s1_eoi_s1))
		else $error("result without end of image");

	a_counts_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && s1_eoi_s1) |=> (totals_q == '0))
		else $error("counts not cleared after image");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> (s1_valid_q && s1_eoi_s1 && out_valid_q))
		else $error("stalled end-of-image item lost");

endmodule
